### rtl/rlpe_pkg.sv
// Shared types and constants for the RGB LED pulse encoder.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package rlpe_pkg;

	localparam int COLOR_BITS   = 24;
	localparam int COLOR_IN_W   = 24;
	localparam int BITS_LEFT_W  = $clog2(COLOR_BITS + 1);
	localparam int PULSE_W      = 15;
	localparam int TICKS_W      = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = PULSE_W'(8);
	localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = PULSE_W'(17);
	localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = PULSE_W'(16);
	localparam logic [PULSE_W-1:0] ONE_LOW_RST   = PULSE_W'(9);
	localparam logic [TICKS_W-1:0] LATCH_RST     = TICKS_W'(6000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_HIGH = 3'd0,
		REG_ZERO_LOW  = 3'd1,
		REG_ONE_HIGH  = 3'd2,
		REG_ONE_LOW   = 3'd3,
		REG_LATCH     = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_HIGH  = 4'b0010,
		PH_LOW   = 4'b0100,
		PH_LATCH = 4'b1000
	} phase_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} command_t;

	typedef struct packed {
		logic [PULSE_W-1:0] zero_high_ticks;
		logic [PULSE_W-1:0] zero_low_ticks;
		logic [PULSE_W-1:0] one_high_ticks;
		logic [PULSE_W-1:0] one_low_ticks;
		logic [TICKS_W-1:0] latch_ticks;
	} timing_cfg_t;

endpackage

`default_nettype wire

### rtl/rlpe_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on rlpe_pkg for field widths.
`default_nettype none

interface rlpe_cmd_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic [rlpe_pkg::COLOR_IN_W-1:0]   color;

	modport source (output valid, output command, output color, input ready);
	modport sink   (input valid, input command, input color, output ready);
endinterface

interface rlpe_res_if;
	logic valid;
	logic ready;
	logic line_level;
	logic busy_res;
	logic frame_done;
	logic load_rejected;

	modport source (output valid, output line_level, output busy_res, output frame_done,
		output load_rejected, input ready);
	modport sink   (input valid, input line_level, input busy_res, input frame_done,
		input load_rejected, output ready);
endinterface

`default_nettype wire

### rtl/rgb_led_pulse_encoder.sv
// RGB LED pulse encoder top level: timing registers and encoder datapath.
// Pipeline: an accepted command beat is held in the input register, then its result beat in the result register.
// Throughput: one command beat per cycle; a stalled result holds the input stage.
// Reset: arst_n clears to idle with no result beat valid and default timing registers.
// Depends on rlpe_pkg, rlpe_if.sv, rlpe_cfg_regs and rlpe_core.
`default_nettype none

module rgb_led_pulse_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	rlpe_cmd_if.sink                         cmd,
	rlpe_res_if.source                       res,
	input  logic                             cfg_we,
	input  logic [rlpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlpe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import rlpe_pkg::*;

	timing_cfg_t timing;

	rlpe_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.timing    (timing)
	);

	rlpe_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.timing (timing),
		.cmd    (cmd),
		.res    (res)
	);

endmodule

`default_nettype wire

### rtl/rlpe_cfg_regs.sv
// Timing register file of the pulse encoder, written through a plain write port.
// Depends on rlpe_pkg.
`default_nettype none

module rlpe_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rlpe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rlpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output rlpe_pkg::timing_cfg_t            timing
);
	import rlpe_pkg::*;

	timing_cfg_t timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.zero_high_ticks <= ZERO_HIGH_RST;
			timing_q.zero_low_ticks  <= ZERO_LOW_RST;
			timing_q.one_high_ticks  <= ONE_HIGH_RST;
			timing_q.one_low_ticks   <= ONE_LOW_RST;
			timing_q.latch_ticks     <= LATCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZERO_HIGH: timing_q.zero_high_ticks <= cfg_wdata[PULSE_W-1:0];
				REG_ZERO_LOW:  timing_q.zero_low_ticks  <= cfg_wdata[PULSE_W-1:0];
				REG_ONE_HIGH:  timing_q.one_high_ticks  <= cfg_wdata[PULSE_W-1:0];
				REG_ONE_LOW:   timing_q.one_low_ticks   <= cfg_wdata[PULSE_W-1:0];
				REG_LATCH:     timing_q.latch_ticks     <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign timing = timing_q;

endmodule

`default_nettype wire

### rtl/rlpe_core.sv
// Encoder datapath: input register, line-coding state update, result register.
// Depends on rlpe_pkg and the channel interfaces in rlpe_if.sv.
`default_nettype none

module rlpe_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rlpe_pkg::timing_cfg_t  timing,
	rlpe_cmd_if.sink               cmd,
	rlpe_res_if.source             res
);
	import rlpe_pkg::*;

	function automatic logic [TICKS_W-1:0] min_one(input logic [TICKS_W-1:0] v);
		min_one = (v == '0) ? TICKS_W'(1) : v;
	endfunction

	logic                    valid_s1;
	logic                    command_s1;
	logic [COLOR_IN_W-1:0]   color_s1;
	logic                    advance_s1;

	phase_t                  phase_q, phase_n;
	logic [TICKS_W-1:0]      ticks_q, ticks_n;
	logic [BITS_LEFT_W-1:0]  bits_q, bits_n;
	logic [COLOR_BITS-1:0]   shift_q, shift_n, load_word, next_word;

	logic level, done, rejected;

	logic out_valid_q, level_q, busy_q, done_q, rejected_q;

	assign advance_s1 = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready  = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1 <= cmd.command;
			color_s1   <= cmd.color;
		end
	end

	assign load_word = COLOR_BITS'(color_s1);
	assign next_word = shift_q << 1;

	always_comb begin
		phase_n  = phase_q;
		ticks_n  = ticks_q;
		bits_n   = bits_q;
		shift_n  = shift_q;
		level    = (phase_q == PH_HIGH);
		done     = 1'b0;
		rejected = 1'b0;
		if (command_s1 == CMD_LOAD) begin
			if (phase_q != PH_IDLE) begin
				rejected = 1'b1;
			end else begin
				shift_n = load_word;
				bits_n  = BITS_LEFT_W'(COLOR_BITS);
				phase_n = PH_HIGH;
				ticks_n = min_one(load_word[COLOR_BITS-1]
					? TICKS_W'(timing.one_high_ticks) : TICKS_W'(timing.zero_high_ticks));
			end
		end else if (phase_q != PH_IDLE) begin
			if (ticks_q > TICKS_W'(1)) begin
				ticks_n = ticks_q - TICKS_W'(1);
			end else begin
				case (phase_q)
					PH_HIGH: begin
						phase_n = PH_LOW;
						ticks_n = min_one(shift_q[COLOR_BITS-1]
							? TICKS_W'(timing.one_low_ticks)
							: TICKS_W'(timing.zero_low_ticks));
					end
					PH_LOW: begin
						if (bits_q > BITS_LEFT_W'(1)) begin
							bits_n  = bits_q - BITS_LEFT_W'(1);
							shift_n = next_word;
							phase_n = PH_HIGH;
							ticks_n = min_one(next_word[COLOR_BITS-1]
								? TICKS_W'(timing.one_high_ticks)
								: TICKS_W'(timing.zero_high_ticks));
						end else begin
							bits_n  = '0;
							shift_n = '0;
							phase_n = PH_LATCH;
							ticks_n = min_one(timing.latch_ticks);
						end
					end
					default: begin
						phase_n = PH_IDLE;
						ticks_n = '0;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			bits_q  <= '0;
			shift_q <= '0;
		end else if (advance_s1) begin
			phase_q <= phase_n;
			ticks_q <= ticks_n;
			bits_q  <= bits_n;
			shift_q <= shift_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			level_q    <= level;
			busy_q     <= (phase_n != PH_IDLE);
			done_q     <= done;
			rejected_q <= rejected;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.line_level    = level_q;
	assign res.busy_res      = busy_q;
	assign res.frame_done    = done_q;
	assign res.load_rejected = rejected_q;

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bits_q == '0 && ticks_q == '0)
		else $error("idle phase with leftover counters");

	a_pulse_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HIGH || phase_q == PH_LOW) |-> bits_q != '0 && ticks_q != '0)
		else $error("pulse phase with empty counters");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_done |-> !res.busy_res && !res.load_rejected)
		else $error("frame done beat still busy");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.load_rejected |-> res.busy_res)
		else $error("load rejected while idle");

endmodule

`default_nettype wire
